[rtl/core/utf8v_pkg.sv]
package utf8v_pkg;

    // Default width of the position, line and column counters
    localparam int COUNT_WIDTH_DEF = 32;

    // Width of an assembled code point
    localparam int CP_WIDTH = 21;

    // Lead byte and continuation byte patterns
    localparam logic [7:0] ASCII_LIMIT   = 8'h80;
    localparam logic [7:0] LINE_FEED     = 8'h0A;
    localparam logic [7:0] LEAD2_MASK    = 8'hE0;
    localparam logic [7:0] LEAD2_CODE    = 8'hC0;
    localparam logic [7:0] LEAD3_MASK    = 8'hF0;
    localparam logic [7:0] LEAD3_CODE    = 8'hE0;
    localparam logic [7:0] LEAD4_MASK    = 8'hF8;
    localparam logic [7:0] LEAD4_CODE    = 8'hF0;
    localparam logic [7:0] CONT_MASK     = 8'hC0;
    localparam logic [7:0] CONT_CODE     = 8'h80;

    // Code point limits
    localparam logic [CP_WIDTH-1:0] SURR_LOW  = 21'h00D800;
    localparam logic [CP_WIDTH-1:0] SURR_HIGH = 21'h00DFFF;
    localparam logic [CP_WIDTH-1:0] CP_MAX    = 21'h10FFFF;

    // Smallest code point allowed for a sequence with 0..3 continuation bytes
    localparam logic [CP_WIDTH-1:0] MIN_CP [4] = '{
        21'h000000, 21'h000080, 21'h000800, 21'h010000
    };

    // One input request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One result request
    typedef struct packed {
        logic        valid_res;
        logic [31:0] error_offset;
        logic [31:0] error_line;
        logic [31:0] error_column;
    } out_item_t;

    // Byte decoder verdict for the sequence tracker
    typedef struct packed {
        logic                start_seq;
        logic                newline;
        logic                err_at_pos;
        logic                err_at_seq;
        logic [1:0]          bytes_left;
        logic [1:0]          seq_length;
        logic [CP_WIDTH-1:0] code_point;
    } step_t;

endpackage

[rtl/core/utf8v_decode.sv]
module utf8v_decode (
    input  logic [7:0]                    data_byte,
    input  logic [1:0]                    bytes_left,
    input  logic [1:0]                    seq_length,
    input  logic [utf8v_pkg::CP_WIDTH-1:0] code_point,
    output utf8v_pkg::step_t              step
);

    logic [utf8v_pkg::CP_WIDTH-1:0] cp_shift;
    logic [1:0]                     left_dec;

    // Shift in the six payload bits of a continuation byte
    assign cp_shift = {code_point[utf8v_pkg::CP_WIDTH-7:0], data_byte[5:0]};
    assign left_dec = bytes_left - 2'd1;

    always_comb
    begin
        step            = '0;
        step.bytes_left = bytes_left;
        step.seq_length = seq_length;
        step.code_point = code_point;

        if (bytes_left == 2'd0)
        begin
            if (data_byte < utf8v_pkg::ASCII_LIMIT)
            begin
                // Plain ASCII: only track line breaks
                step.newline = (data_byte == utf8v_pkg::LINE_FEED);
            end
            else
            begin
                // Classify the lead byte and open a sequence
                step.start_seq = 1'b1;
                if ((data_byte & utf8v_pkg::LEAD2_MASK) == utf8v_pkg::LEAD2_CODE)
                begin
                    step.seq_length = 2'd1;
                    step.code_point = utf8v_pkg::CP_WIDTH'(data_byte[4:0]);
                end
                else if ((data_byte & utf8v_pkg::LEAD3_MASK) == utf8v_pkg::LEAD3_CODE)
                begin
                    step.seq_length = 2'd2;
                    step.code_point = utf8v_pkg::CP_WIDTH'(data_byte[3:0]);
                end
                else if ((data_byte & utf8v_pkg::LEAD4_MASK) == utf8v_pkg::LEAD4_CODE)
                begin
                    step.seq_length = 2'd3;
                    step.code_point = utf8v_pkg::CP_WIDTH'(data_byte[2:0]);
                end
                else
                begin
                    step.seq_length = 2'd0;
                    step.err_at_pos = 1'b1;
                end
                step.bytes_left = step.seq_length;
            end
        end
        else if ((data_byte & utf8v_pkg::CONT_MASK) != utf8v_pkg::CONT_CODE)
        begin
            // Missing continuation byte: drop the sequence
            step.bytes_left = 2'd0;
            step.err_at_seq = 1'b1;
        end
        else
        begin
            // Advance the sequence; check the finished code point
            step.code_point = cp_shift;
            step.bytes_left = left_dec;
            if (left_dec == 2'd0)
            begin
                step.err_at_seq = (cp_shift < utf8v_pkg::MIN_CP[seq_length])
                               || ((cp_shift >= utf8v_pkg::SURR_LOW)
                                   && (cp_shift <= utf8v_pkg::SURR_HIGH))
                               || (cp_shift > utf8v_pkg::CP_MAX);
            end
        end
    end

endmodule

[rtl/core/utf8_stream_validator.sv]
// An accepted last byte passes the input register, then its result is loaded into the result register.
// Throughput: one byte per cycle, except while a last byte waits on an unread result;
// the sequence and counter state is updated by a single registered pass per byte.
// A last byte waits in the input register only while a previous result is unread.
// Reset (rst_n low, asynchronous) clears all stream state; the block also
// returns to that state after each last byte.
module utf8_stream_validator #(
    parameter int COUNT_WIDTH = utf8v_pkg::COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  utf8v_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output utf8v_pkg::out_item_t out_data
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ZERO = '0;
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE  = COUNT_WIDTH'(1);

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] x);
        return (x == CNT_MAX) ? x : x + CNT_ONE;
    endfunction

    // Input register
    logic                in_valid_reg;
    utf8v_pkg::in_item_t in_data_reg;

    // Stream state
    logic [1:0]                     bytes_left_reg,  bytes_left_next;
    logic [1:0]                     seq_length_reg,  seq_length_next;
    logic [utf8v_pkg::CP_WIDTH-1:0] code_point_reg,  code_point_next;
    logic [COUNT_WIDTH-1:0]         byte_index_reg,  byte_index_next;
    logic [COUNT_WIDTH-1:0]         seq_start_reg,   seq_start_next;
    logic [COUNT_WIDTH-1:0]         line_number_reg, line_number_next;
    logic [COUNT_WIDTH-1:0]         line_begin_reg,  line_begin_next;
    logic                           error_seen_reg,  error_seen_next;
    logic [COUNT_WIDTH-1:0]         bad_offset_reg,  bad_offset_next;
    logic [COUNT_WIDTH-1:0]         bad_line_reg,    bad_line_next;
    logic [COUNT_WIDTH-1:0]         bad_column_reg,  bad_column_next;

    // Result register
    logic                 out_valid_reg;
    utf8v_pkg::out_item_t out_data_reg, out_data_next;

    utf8v_pkg::step_t       step;
    logic                   fire;
    logic                   latch;
    logic [COUNT_WIDTH-1:0] col_diff;

    // Byte decoder
    utf8v_decode u_decode (
        .data_byte  (in_data_reg.data_byte),
        .bytes_left (bytes_left_reg),
        .seq_length (seq_length_reg),
        .code_point (code_point_reg),
        .step       (step)
    );

    // Process the held byte unless it is a last byte facing a full result slot
    assign fire     = in_valid_reg
                   && (!in_data_reg.last_byte || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    // Next stream state for the held byte
    always_comb
    begin
        bytes_left_next  = bytes_left_reg;
        seq_length_next  = seq_length_reg;
        code_point_next  = code_point_reg;
        byte_index_next  = byte_index_reg;
        seq_start_next   = seq_start_reg;
        line_number_next = line_number_reg;
        line_begin_next  = line_begin_reg;
        latch            = 1'b0;

        if (!error_seen_reg)
        begin
            bytes_left_next = step.bytes_left;
            seq_length_next = step.seq_length;
            code_point_next = step.code_point;
            byte_index_next = sat_inc(byte_index_reg);
            if (step.start_seq)
            begin
                seq_start_next = byte_index_reg;
            end
            if (step.newline)
            begin
                line_number_next = sat_inc(line_number_reg);
                line_begin_next  = sat_inc(byte_index_reg);
            end
            // Bad byte, or stream cut off inside a sequence
            latch = step.err_at_pos || step.err_at_seq
                 || (in_data_reg.last_byte && (step.bytes_left != 2'd0));
        end

        // Record the first bad sequence start
        col_diff        = (seq_start_next >= line_begin_reg)
                        ? seq_start_next - line_begin_reg : CNT_ZERO;
        error_seen_next = error_seen_reg || latch;
        bad_offset_next = latch ? seq_start_next    : bad_offset_reg;
        bad_line_next   = latch ? line_number_reg   : bad_line_reg;
        bad_column_next = latch ? sat_inc(col_diff) : bad_column_reg;
    end

    // Result of a last byte
    always_comb
    begin
        out_data_next.valid_res    = !error_seen_next;
        out_data_next.error_offset = error_seen_next ? 32'(bad_offset_next)
                                                     : 32'(byte_index_next);
        out_data_next.error_line   = 32'(bad_line_next);
        out_data_next.error_column = 32'(bad_column_next);
    end

    // Hold one byte between the input channel and the state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // Advance the stream state; restart after a last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg  <= 2'd0;
            seq_length_reg  <= 2'd0;
            code_point_reg  <= '0;
            byte_index_reg  <= CNT_ZERO;
            seq_start_reg   <= CNT_ZERO;
            line_number_reg <= CNT_ONE;
            line_begin_reg  <= CNT_ZERO;
            error_seen_reg  <= 1'b0;
            bad_offset_reg  <= CNT_ZERO;
            bad_line_reg    <= CNT_ONE;
            bad_column_reg  <= CNT_ONE;
        end
        else if (fire)
        begin
            if (in_data_reg.last_byte)
            begin
                bytes_left_reg  <= 2'd0;
                seq_length_reg  <= 2'd0;
                code_point_reg  <= '0;
                byte_index_reg  <= CNT_ZERO;
                seq_start_reg   <= CNT_ZERO;
                line_number_reg <= CNT_ONE;
                line_begin_reg  <= CNT_ZERO;
                error_seen_reg  <= 1'b0;
                bad_offset_reg  <= CNT_ZERO;
                bad_line_reg    <= CNT_ONE;
                bad_column_reg  <= CNT_ONE;
            end
            else
            begin
                bytes_left_reg  <= bytes_left_next;
                seq_length_reg  <= seq_length_next;
                code_point_reg  <= code_point_next;
                byte_index_reg  <= byte_index_next;
                seq_start_reg   <= seq_start_next;
                line_number_reg <= line_number_next;
                line_begin_reg  <= line_begin_next;
                error_seen_reg  <= error_seen_next;
                bad_offset_reg  <= bad_offset_next;
                bad_line_reg    <= bad_line_next;
                bad_column_reg  <= bad_column_next;
            end
        end
    end

    // Result register: load on a last byte, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && in_data_reg.last_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && in_data_reg.last_byte)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/core/utf8v_checker.sv]
module utf8v_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input utf8v_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input utf8v_pkg::out_item_t out_data
);

    // A stalled result request holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // With no result pending the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

    // A valid stream reports line one, column one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.valid_res |->
            (out_data.error_line == 32'd1) && (out_data.error_column == 32'd1))
        else $error("valid stream with error position");

    // An accepted last byte leads to a result being offered
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.last_byte |=> ##1 out_valid)
        else $error("no result after last byte");

    // The input stalls only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

endmodule

bind utf8_stream_validator utf8v_checker u_utf8v_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
